// ===== rtl/carf_pkg.sv =====
// ----------------------------------------------------------------------------
// carf_pkg: shared types and constants for the clipped alpha rectangle fill
// Opcodes, result codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package carf_pkg;

  localparam int unsigned OP_W    = 16;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned CODE_W  = 2;

  localparam logic [OP_W-1:0] OP_NONE  = 16'h0000;
  localparam logic [OP_W-1:0] OP_BLIT  = 16'h0001;
  localparam logic [OP_W-1:0] OP_CLIP  = 16'h0002;
  localparam logic [OP_W-1:0] OP_WRITE = 16'h0003;
  localparam logic [OP_W-1:0] OP_READ  = 16'h0004;

  localparam logic [CODE_W-1:0] RC_DONE    = 2'd0;
  localparam logic [CODE_W-1:0] RC_EMPTY   = 2'd1;
  localparam logic [CODE_W-1:0] RC_UNKNOWN = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 15'h7FFF;
  localparam logic [7:0]       ALPHA_FULL = 8'hFF;
  localparam logic [7:0]       ALPHA_ZERO = 8'h00;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_FILL,
    ST_DRAIN,
    ST_RD_WAIT,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/carf_ram.sv =====
// ----------------------------------------------------------------------------
// carf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module carf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/carf_blend.sv =====
// ----------------------------------------------------------------------------
// carf_blend: ARGB source-over blend unit
// Full alpha replaces, zero alpha keeps, else mixes RGB and keeps max alpha.
// ----------------------------------------------------------------------------
module carf_blend (
  input  logic [carf_pkg::PIX_W-1:0] old_pix,
  input  logic [carf_pkg::PIX_W-1:0] src_pix,
  output logic [carf_pkg::PIX_W-1:0] res_pix
);

  logic [7:0]  a;
  logic [7:0]  oa;
  logic [7:0]  inv_a;
  logic [15:0] mix [3];
  logic [carf_pkg::PIX_W-1:0] mixed;

  assign a     = src_pix[31:24];
  assign oa    = old_pix[31:24];
  assign inv_a = carf_pkg::ALPHA_FULL - a;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix[i] = 16'(inv_a) * 16'(old_pix[i*8 +: 8]) + 16'(a) * 16'(src_pix[i*8 +: 8]);
    end
    mixed = {((oa > a) ? oa : a), mix[2][15:8], mix[1][15:8], mix[0][15:8]};
  end

  always_comb begin
    if (a == carf_pkg::ALPHA_FULL) begin
      res_pix = src_pix;
    end else if (a == carf_pkg::ALPHA_ZERO) begin
      res_pix = old_pix;
    end else begin
      res_pix = mixed;
    end
  end

endmodule

// ===== rtl/clipped_alpha_rect_fill.sv =====
// ----------------------------------------------------------------------------
// clipped_alpha_rect_fill: 2D fill engine with clip rectangle and alpha blend
// Holds an ARGB frame and a clip rectangle; runs one command item at a time.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------------
//   in      | input     | in_valid, in_ready, opcode, rect_x/y/w/h, color
//   out     | output    | out_valid, out_ready, read_pixel, pixels_drawn,
//           |           | result_code
//
// Blit: decode, check, then one pixel per cycle through the frame RAM
// read-blend-write loop; an empty clipped area skips the fill. Read pixel
// waits for the RAM read; other commands go from decode to the final state.
// After reset a clear pass writes zero to all FRAME_WIDTH*FRAME_HEIGHT words,
// one per cycle, with in_ready low. A finished item waits in the output
// register; the sequencer holds in FIN while it is full and out_ready is low.
// ----------------------------------------------------------------------------
module clipped_alpha_rect_fill #(
  parameter int unsigned FRAME_WIDTH  = 128,
  parameter int unsigned FRAME_HEIGHT = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [carf_pkg::OP_W-1:0]    in_opcode,
  input  logic [carf_pkg::COORD_W-1:0] in_rect_x,
  input  logic [carf_pkg::COORD_W-1:0] in_rect_y,
  input  logic [carf_pkg::COORD_W-1:0] in_rect_w,
  input  logic [carf_pkg::COORD_W-1:0] in_rect_h,
  input  logic [carf_pkg::PIX_W-1:0]   in_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [carf_pkg::PIX_W-1:0]   out_read_pixel,
  output logic [carf_pkg::CNT_W-1:0]   out_pixels_drawn,
  output logic [carf_pkg::CODE_W-1:0]  out_result_code
);

  localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(FRAME_WIDTH + 1);
  localparam int unsigned RW    = $clog2(FRAME_HEIGHT + 1);
  localparam int unsigned TW    = CW + RW;

  carf_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [carf_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [carf_pkg::COORD_W-1:0] x_r, x_nxt, y_r, y_nxt, w_r, w_nxt, h_r, h_nxt;
  logic [carf_pkg::PIX_W-1:0]   color_r, color_nxt;
  logic [carf_pkg::COORD_W-1:0] clip_l_r, clip_l_nxt, clip_t_r, clip_t_nxt;
  logic [carf_pkg::COORD_W-1:0] clip_w_r, clip_w_nxt, clip_h_r, clip_h_nxt;
  logic [carf_pkg::COORD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CW-1:0] ex_r, ex_nxt, col_r, col_nxt;
  logic [RW-1:0] ey_r, ey_nxt, row_r, row_nxt;
  logic [AW-1:0] base_r, base_nxt, paddr_r, paddr_nxt;
  logic          pend_r, pend_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [carf_pkg::PIX_W-1:0]  res_pix_r, res_pix_nxt;
  logic [carf_pkg::CODE_W-1:0] res_code_r, res_code_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [carf_pkg::PIX_W-1:0]  out_pix_r, out_pix_nxt;
  logic [carf_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [carf_pkg::CODE_W-1:0] out_code_r, out_code_nxt;

  logic [16:0] x_end, y_end, clip_xe, clip_ye, ex_full, ey_full;
  logic        in_frame;
  logic [AW-1:0] pix_addr, fill_addr;
  logic [CW-1:0] dx, col_inc;
  logic [RW-1:0] dy, row_inc;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [carf_pkg::PIX_W-1:0] ram_wdata, ram_rdata, blend_pix;

  carf_ram #(
    .WIDTH (carf_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  carf_blend u_blend (
    .old_pix (ram_rdata),
    .src_pix (color_r),
    .res_pix (blend_pix)
  );

  // clip window
  always_comb begin
    x_end   = 17'(x_r) + 17'(w_r);
    y_end   = 17'(y_r) + 17'(h_r);
    clip_xe = 17'(clip_l_r) + 17'(clip_w_r);
    clip_ye = 17'(clip_t_r) + 17'(clip_h_r);
    ex_full = (x_end < clip_xe) ? x_end : clip_xe;
    ey_full = (y_end < clip_ye) ? y_end : clip_ye;
    if (ex_full > 17'(FRAME_WIDTH)) begin
      ex_full = 17'(FRAME_WIDTH);
    end
    if (ey_full > 17'(FRAME_HEIGHT)) begin
      ey_full = 17'(FRAME_HEIGHT);
    end
    in_frame  = (32'(x_r) < 32'(FRAME_WIDTH)) && (32'(y_r) < 32'(FRAME_HEIGHT));
    pix_addr  = AW'(AW'(y_r) * AW'(FRAME_WIDTH) + AW'(x_r));
    fill_addr = AW'(base_r + AW'(col_r));
    dx        = CW'(ex_r - sx_r[CW-1:0]);
    dy        = RW'(ey_r - sy_r[RW-1:0]);
    col_inc   = CW'(col_r + CW'(1));
    row_inc   = RW'(row_r + RW'(1));
  end

  // frame port select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pix_addr;
    ram_wdata = color_r;
    ram_raddr = (state_r == carf_pkg::ST_FILL) ? fill_addr : pix_addr;
    if (state_r == carf_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r;
      ram_wdata = '0;
    end else if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = paddr_r;
      ram_wdata = blend_pix;
    end else if (state_r == carf_pkg::ST_DECODE && op_r == carf_pkg::OP_WRITE && in_frame) begin
      ram_we = 1'b1;
    end
  end

  assign in_ready = (state_r == carf_pkg::ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    color_nxt     = color_r;
    clip_l_nxt    = clip_l_r;
    clip_t_nxt    = clip_t_r;
    clip_w_nxt    = clip_w_r;
    clip_h_nxt    = clip_h_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    paddr_nxt     = fill_addr;
    pend_nxt      = (state_r == carf_pkg::ST_FILL);
    total_nxt     = total_r;
    res_pix_nxt   = res_pix_r;
    res_code_nxt  = res_code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pix_nxt   = out_pix_r;
    out_cnt_nxt   = out_cnt_r;
    out_code_nxt  = out_code_r;

    case (state_r)
      carf_pkg::ST_CLEAR: begin
        cnt_nxt = AW'(cnt_r + AW'(1));
        if (32'(cnt_r) == DEPTH - 1) begin
          state_nxt = carf_pkg::ST_IDLE;
        end
      end
      carf_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          x_nxt     = in_rect_x;
          y_nxt     = in_rect_y;
          w_nxt     = in_rect_w;
          h_nxt     = in_rect_h;
          color_nxt = in_color;
          state_nxt = carf_pkg::ST_DECODE;
        end
      end
      carf_pkg::ST_DECODE: begin
        res_pix_nxt  = '0;
        res_code_nxt = carf_pkg::RC_DONE;
        total_nxt    = '0;
        state_nxt    = carf_pkg::ST_FIN;
        case (op_r)
          carf_pkg::OP_NONE: begin
          end
          carf_pkg::OP_BLIT: begin
            sx_nxt    = (x_r > clip_l_r) ? x_r : clip_l_r;
            sy_nxt    = (y_r > clip_t_r) ? y_r : clip_t_r;
            ex_nxt    = CW'(ex_full);
            ey_nxt    = RW'(ey_full);
            state_nxt = carf_pkg::ST_CHECK;
          end
          carf_pkg::OP_CLIP: begin
            clip_l_nxt = x_r;
            clip_t_nxt = y_r;
            clip_w_nxt = w_r;
            clip_h_nxt = h_r;
          end
          carf_pkg::OP_WRITE: begin
          end
          carf_pkg::OP_READ: begin
            state_nxt = carf_pkg::ST_RD_WAIT;
          end
          default: begin
            res_code_nxt = carf_pkg::RC_UNKNOWN;
          end
        endcase
      end
      carf_pkg::ST_CHECK: begin
        if (16'(ex_r) <= sx_r || 16'(ey_r) <= sy_r) begin
          res_code_nxt = carf_pkg::RC_EMPTY;
          state_nxt    = carf_pkg::ST_FIN;
        end else begin
          total_nxt = TW'(TW'(dx) * TW'(dy));
          col_nxt   = sx_r[CW-1:0];
          row_nxt   = sy_r[RW-1:0];
          base_nxt  = AW'(AW'(sy_r[RW-1:0]) * AW'(FRAME_WIDTH));
          state_nxt = carf_pkg::ST_FILL;
        end
      end
      carf_pkg::ST_FILL: begin
        if (col_inc == ex_r) begin
          col_nxt  = sx_r[CW-1:0];
          row_nxt  = row_inc;
          base_nxt = AW'(base_r + AW'(FRAME_WIDTH));
          if (row_inc == ey_r) begin
            state_nxt = carf_pkg::ST_DRAIN;
          end
        end else begin
          col_nxt = col_inc;
        end
      end
      carf_pkg::ST_DRAIN: begin
        state_nxt = carf_pkg::ST_FIN;
      end
      carf_pkg::ST_RD_WAIT: begin
        if (in_frame) begin
          res_pix_nxt = ram_rdata;
        end
        state_nxt = carf_pkg::ST_FIN;
      end
      carf_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = res_pix_r;
          out_code_nxt  = res_code_r;
          out_cnt_nxt   = (32'(total_r) > 32'(carf_pkg::COUNT_MAX)) ?
                          carf_pkg::COUNT_MAX : carf_pkg::CNT_W'(total_r);
          state_nxt     = carf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = carf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= carf_pkg::ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      clip_l_r    <= '0;
      clip_t_r    <= '0;
      clip_w_r    <= carf_pkg::COORD_W'(FRAME_WIDTH);
      clip_h_r    <= carf_pkg::COORD_W'(FRAME_HEIGHT);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      clip_l_r    <= clip_l_nxt;
      clip_t_r    <= clip_t_nxt;
      clip_w_r    <= clip_w_nxt;
      clip_h_r    <= clip_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    color_r    <= color_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    paddr_r    <= paddr_nxt;
    total_r    <= total_nxt;
    res_pix_r  <= res_pix_nxt;
    res_code_r <= res_code_nxt;
    out_pix_r  <= out_pix_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_code_r <= out_code_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_pixel   = out_pix_r;
  assign out_pixels_drawn = out_cnt_r;
  assign out_result_code  = out_code_r;

endmodule
